FILE: rtl/mandelbrot_escape_count_macros.svh
// assertion helpers used by mec_core
`ifndef MANDELBROT_ESCAPE_COUNT_MACROS_SVH
`define MANDELBROT_ESCAPE_COUNT_MACROS_SVH

// same-cycle implication, held off during reset
`define MEC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mec_pkg.sv
`default_nettype none

package mec_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned MUL_W     = DATA_W / 2;
  localparam int unsigned COUNT_W   = 20;
  localparam int unsigned NUM_STEPS = 11;
  localparam int unsigned STEP_W    = $clog2(NUM_STEPS);

  localparam logic [COUNT_W-1:0] MAX_COUNT_RST = COUNT_W'(1000);

  // operand half fed to the shared multiplier
  typedef enum logic [1:0] {
    OP_A_LO,
    OP_A_HI,
    OP_B_LO,
    OP_B_HI
  } mec_opsel_e;

  // accumulator that takes the previous product
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_A2,
    ACC_B2,
    ACC_AB
  } mec_acc_e;

  // weight of the previous product in its accumulator
  typedef enum logic [1:0] {
    SH_NONE,      // lo * lo
    SH_HALF,      // one cross term
    SH_HALF_DBL,  // cross term counted twice in a square
    SH_FULL       // hi * hi
  } mec_shift_e;

  typedef struct packed {
    mec_opsel_e x;
    mec_opsel_e y;
    mec_acc_e   acc;
    mec_shift_e sh;
    logic       first;
  } mec_step_t;

  // per step: operands issued now, accumulation of the product issued last step
  localparam mec_step_t STEP_TAB [NUM_STEPS] = '{
    '{OP_A_LO, OP_A_LO, ACC_NONE, SH_NONE,     1'b0},
    '{OP_A_LO, OP_A_HI, ACC_A2,   SH_NONE,     1'b1},
    '{OP_A_HI, OP_A_HI, ACC_A2,   SH_HALF_DBL, 1'b0},
    '{OP_B_LO, OP_B_LO, ACC_A2,   SH_FULL,     1'b0},
    '{OP_B_LO, OP_B_HI, ACC_B2,   SH_NONE,     1'b1},
    '{OP_B_HI, OP_B_HI, ACC_B2,   SH_HALF_DBL, 1'b0},
    '{OP_A_LO, OP_B_LO, ACC_B2,   SH_FULL,     1'b0},
    '{OP_A_LO, OP_B_HI, ACC_AB,   SH_NONE,     1'b1},
    '{OP_A_HI, OP_B_LO, ACC_AB,   SH_HALF,     1'b0},
    '{OP_A_HI, OP_B_HI, ACC_AB,   SH_HALF,     1'b0},
    '{OP_A_LO, OP_A_LO, ACC_AB,   SH_FULL,     1'b0}
  };

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } mec_res_t;

endpackage

`default_nettype wire

FILE: rtl/mec_stream_if.sv
`default_nettype none

interface mec_point_if import mec_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] cx;
  logic signed [DATA_W-1:0] cy;

  modport source (output valid, output cx, output cy, input ready);
  modport sink (input valid, input cx, input cy, output ready);
endinterface

interface mec_count_if import mec_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output count, input ready);
  modport sink (input valid, input count, output ready);
endinterface

`default_nettype wire

FILE: rtl/mec_mul.sv
`default_nettype none

module mec_mul import mec_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic [MUL_W-1:0]     x_i,
  input  wire logic [MUL_W-1:0]     y_i,
  output logic      [2*MUL_W-1:0]   p_o
);

  logic [2*MUL_W-1:0] p_d;
  logic [2*MUL_W-1:0] p_q;

  assign p_d = (2*MUL_W)'(x_i) * (2*MUL_W)'(y_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/mec_core.sv
`default_nettype none

`include "mandelbrot_escape_count_macros.svh"

module mec_core import mec_pkg::*; #(
  parameter int unsigned FRAC_BITS = 60
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [COUNT_W-1:0] max_count_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [DATA_W-1:0]  cx_i,
  input  wire logic [DATA_W-1:0]  cy_i,
  output mec_res_t                res_o,
  input  wire logic               res_ready_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ABS  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_TEST = 3'd3;
  localparam logic [2:0] ST_DIFF = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  localparam int unsigned ACC_W = 2 * DATA_W;
  localparam int unsigned SUM_W = ACC_W + 1;
  localparam logic [SUM_W-1:0] ESC_THR = {{(SUM_W-1){1'b0}}, 1'b1} << (2*FRAC_BITS + 2);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  logic [2:0]         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [COUNT_W-1:0] count_inc;

  logic [DATA_W-1:0]  cx_q, cy_q, a_q, b_q, ua_q, ub_q;
  logic               neg_q;
  logic [ACC_W-1:0]   a2_q, b2_q, ab_q;

  mec_step_t          cur;
  logic [MUL_W-1:0]   mul_x, mul_y;
  logic [DATA_W-1:0]  mul_p;
  logic [ACC_W-1:0]   term, acc_sel, acc_sum;
  logic [SUM_W-1:0]   mag_sum;
  logic               escape;

  function automatic logic [MUL_W-1:0] pick(mec_opsel_e sel, logic [DATA_W-1:0] ua,
                                            logic [DATA_W-1:0] ub);
    logic [MUL_W-1:0] v;
    unique case (sel)
      OP_A_LO: v = ua[MUL_W-1:0];
      OP_A_HI: v = ua[DATA_W-1:MUL_W];
      OP_B_LO: v = ub[MUL_W-1:0];
      OP_B_HI: v = ub[DATA_W-1:MUL_W];
      default: v = ua[MUL_W-1:0];
    endcase
    return v;
  endfunction

  assign cur   = STEP_TAB[step_q];
  assign mul_x = pick(cur.x, ua_q, ub_q);
  assign mul_y = pick(cur.y, ua_q, ub_q);

  mec_mul u_mul (
    .clk_i (clk_i),
    .x_i   (mul_x),
    .y_i   (mul_y),
    .p_o   (mul_p)
  );

  // place the last product at its weight
  always_comb begin
    unique case (cur.sh)
      SH_NONE:     term = {{DATA_W{1'b0}}, mul_p};
      SH_HALF:     term = {{(DATA_W-MUL_W){1'b0}}, mul_p, {MUL_W{1'b0}}};
      SH_HALF_DBL: term = {{(DATA_W-MUL_W-1){1'b0}}, mul_p, {(MUL_W+1){1'b0}}};
      SH_FULL:     term = {mul_p, {DATA_W{1'b0}}};
      default:     term = {{DATA_W{1'b0}}, mul_p};
    endcase
  end

  always_comb begin
    unique case (cur.acc)
      ACC_A2:  acc_sel = a2_q;
      ACC_B2:  acc_sel = b2_q;
      ACC_AB:  acc_sel = ab_q;
      default: acc_sel = '0;
    endcase
  end

  assign acc_sum   = (cur.first ? '0 : acc_sel) + term;
  assign mag_sum   = {1'b0, a2_q} + {1'b0, b2_q};
  assign escape    = mag_sum > ESC_THR;
  assign count_inc = count_q + 1'b1;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          count_d = '0;
          state_d = (max_count_i == '0) ? ST_DONE : ST_ABS;
        end
      end
      ST_ABS: begin
        step_d  = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = ST_TEST;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_TEST: state_d = escape ? ST_DONE : ST_DIFF;
      ST_DIFF: state_d = ST_UPD;
      ST_UPD: begin
        count_d = count_inc;
        state_d = (count_inc == max_count_i) ? ST_DONE : ST_ABS;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cx_q <= cx_i;
          cy_q <= cy_i;
          a_q  <= cx_i;
          b_q  <= cy_i;
        end
      end
      ST_ABS: begin
        ua_q  <= a_q[DATA_W-1] ? -a_q : a_q;
        ub_q  <= b_q[DATA_W-1] ? -b_q : b_q;
        neg_q <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
      end
      ST_MUL: begin
        unique case (cur.acc)
          ACC_A2:  a2_q <= acc_sum;
          ACC_B2:  b2_q <= acc_sum;
          ACC_AB:  ab_q <= acc_sum;
          default: ;
        endcase
      end
      ST_DIFF: begin
        a2_q <= a2_q - b2_q;
        ab_q <= neg_q ? -ab_q : ab_q;
      end
      ST_UPD: begin
        // floor shift of a^2-b^2 and of 2ab, then add c
        a_q <= a2_q[FRAC_BITS +: DATA_W] + cx_q;
        b_q <= ab_q[FRAC_BITS-1 +: DATA_W] + cy_q;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.count = count_q;

  `MEC_ASSERT_IMP(a_step_range, clk_i, rst_ni, state_q == ST_MUL, step_q <= LAST_STEP, "step out of range")
  `MEC_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "point taken while busy")
  `MEC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_o.valid && !res_ready_i, res_o.valid && $stable(res_o.count), "result dropped")
  `MEC_ASSERT_NEXT(a_count_step, clk_i, rst_ni, state_q == ST_UPD, count_q == $past(count_q) + 1'b1, "count skipped")

endmodule

`default_nettype wire

FILE: rtl/mandelbrot_escape_count.sv
// channel   dir  modport  payload                 request moves
// point_i   in   sink     cx, cy (signed Q4.60)   one point c to iterate
// count_o   out  source   count (20 bit)          escape count of one point
//
// one shared 32x32 multiplier builds a^2, b^2 and ab from ten partial products,
// so each iteration runs through magnitudes, 11 multiply steps, test, diff and update
// a point is taken only while the core is idle; the output register holds a result
// so the next point can start while count_o stalls
// reset sets max_count to 1000 and empties the core and the output register
`default_nettype none

module mandelbrot_escape_count import mec_pkg::*; #(
  parameter int unsigned FRAC_BITS = 60
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               max_count_we_i,
  input  wire logic [COUNT_W-1:0] max_count_i,
  mec_point_if.sink               point_i,
  mec_count_if.source             count_o
);

  // iteration limit; the user must write it only while idle, the block does not enforce this
  logic [COUNT_W-1:0] max_count_q;

  // core result request toward the output register
  mec_res_t           core_res;
  logic               core_res_ready;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= MAX_COUNT_RST;
    end else if (max_count_we_i) begin
      max_count_q <= max_count_i;
    end
  end

  mec_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_count_i (max_count_q),
    .in_valid_i  (point_i.valid),
    .in_ready_o  (point_i.ready),
    .cx_i        (point_i.cx),
    .cy_i        (point_i.cy),
    .res_o       (core_res),
    .res_ready_i (core_res_ready)
  );

  // the register takes a new count when empty or when its count leaves this cycle
  assign core_res_ready = !out_valid_q || count_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (core_res.valid && core_res_ready) begin
      out_valid_d = 1'b1;
    end else if (count_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (core_res.valid && core_res_ready) begin
      out_count_q <= core_res.count;
    end
  end

  assign count_o.valid = out_valid_q;
  assign count_o.count = out_count_q;

endmodule

`default_nettype wire
